// ===== design/rcf_pkg.sv =====
// Shared types and constants for the remote code channel and repeat filter.
`default_nettype none

package rcf_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int IN_CODE_BYTES  = 5;
    localparam int OUT_CODE_BYTES = 5;
    localparam int LENGTH_BITS    = 5;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [BYTE_BITS-1:0]     NIBBLE_MASK   = 8'h0F;
    localparam logic [BYTE_BITS-1:0]     CHANNEL_LIMIT = 8'd16;
    localparam logic [CFG_DATA_BITS-1:0] MASK_RESET    = 16'hFFFF;
    localparam logic [CFG_DATA_BITS-1:0] REPEAT_RESET  = 16'd10;

    typedef enum logic [1:0] {
        REASON_OK         = 2'd0,
        REASON_BAD_LENGTH = 2'd1,
        REASON_MASKED     = 2'd2,
        REASON_REPEAT     = 2'd3
    } reason_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_REMOTE_FORMAT     = 2'd0,
        REG_CHANNEL_MASK      = 2'd1,
        REG_KEEP_CHANNEL_BITS = 2'd2,
        REG_REPEAT_TICKS      = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic                     remote_format;
        logic [CFG_DATA_BITS-1:0] channel_mask;
        logic                     keep_channel_bits;
        logic [CFG_DATA_BITS-1:0] repeat_ticks;
    } cfg_t;

    typedef struct packed {
        logic                                     tick;
        logic [LENGTH_BITS-1:0]                   byte_count;
        logic [IN_CODE_BYTES-1:0][BYTE_BITS-1:0]  code_bytes;
    } item_t;

    typedef struct packed {
        logic                                     accepted;
        reason_t                                  reason;
        logic [BYTE_BITS-1:0]                     channel;
        logic [OUT_CODE_BYTES-1:0][BYTE_BITS-1:0] out_bytes;
    } result_t;

endpackage

`default_nettype wire

// ===== design/remote_code_channel_repeat_filter.sv =====
// Top level of the remote code channel and repeat filter.
//
//  channel  | handshake           | word carries
//  ---------+---------------------+--------------------------------------------------
//  in       | in_valid/in_ready   | req_type, byte_count, code_byte_0..4
//  out      | out_valid/out_ready | accepted, reject_reason, channel, out_byte_0..4
//  cfg      | cfg_valid/cfg_ready | cfg_index (register number), cfg_data
//
// One word per cycle while the out channel does not stall: each word sits in the input
// register, where the filter logic and the last-code store act on it, and a code word's
// result is then registered for the out channel.
// Tick words advance the elapsed counter and leave no result.
// Reset is asynchronous, active low; configuration takes its reset values at once.
// A stalled out channel holds a code word in the input register and backs up into in_ready;
// a waiting result does not block a tick, nor a word entering behind a tick.
`default_nettype none

module remote_code_channel_repeat_filter
#(
    parameter int CODE_BYTES     = 5,
    parameter int MIN_CODE_BYTES = 3,
    parameter int TICK_BITS      = 16
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               req_type,
    input  wire logic [4:0]                         byte_count,
    input  wire logic [7:0]                         code_byte_0,
    input  wire logic [7:0]                         code_byte_1,
    input  wire logic [7:0]                         code_byte_2,
    input  wire logic [7:0]                         code_byte_3,
    input  wire logic [7:0]                         code_byte_4,

    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    accepted,
    output logic [1:0]                              reject_reason,
    output logic [7:0]                              channel,
    output logic [7:0]                              out_byte_0,
    output logic [7:0]                              out_byte_1,
    output logic [7:0]                              out_byte_2,
    output logic [7:0]                              out_byte_3,
    output logic [7:0]                              out_byte_4,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rcf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [rcf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    rcf_pkg::cfg_t    cfg;
    rcf_pkg::item_t   s1_item_reg;
    rcf_pkg::result_t filt_result;
    rcf_pkg::result_t out_res_reg;
    logic             s1_valid_reg;
    logic             out_valid_reg;
    logic             out_free;
    logic             s1_go;

    rcf_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The out slot is free when empty or being emptied this edge. Ticks never
    // need it, so they leave the input register regardless.
    assign out_free = !out_valid_reg || out_ready;
    assign s1_go    = s1_valid_reg && (s1_item_reg.tick || out_free);
    assign in_ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg.tick       <= req_type;
            s1_item_reg.byte_count <= byte_count;
            s1_item_reg.code_bytes <= {code_byte_4, code_byte_3, code_byte_2,
                                       code_byte_1, code_byte_0};
        end
    end

    rcf_filter
    #(
        .CODE_BYTES     (CODE_BYTES),
        .MIN_CODE_BYTES (MIN_CODE_BYTES),
        .TICK_BITS      (TICK_BITS)
    )
    u_filter
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_go),
        .item   (s1_item_reg),
        .cfg    (cfg),
        .result (filt_result)
    );

    // Result register: filled by a code word leaving the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg && !s1_item_reg.tick;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && !s1_item_reg.tick)
        begin
            out_res_reg <= filt_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = out_res_reg.accepted;
    assign reject_reason = out_res_reg.reason;
    assign channel       = out_res_reg.channel;
    assign out_byte_0    = out_res_reg.out_bytes[0];
    assign out_byte_1    = out_res_reg.out_bytes[1];
    assign out_byte_2    = out_res_reg.out_bytes[2];
    assign out_byte_3    = out_res_reg.out_bytes[3];
    assign out_byte_4    = out_res_reg.out_bytes[4];

    a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("input register lost a stalled word");

    a_reject_zero_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_res_reg.accepted |-> out_res_reg.out_bytes == '0)
        else $error("rejected result carries code bytes");

endmodule

`default_nettype wire

// ===== design/rcf_cfg_regs.sv =====
// Configuration register bank of the remote code filter.
`default_nettype none

module rcf_cfg_regs
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rcf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [rcf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output rcf_pkg::cfg_t                           cfg
);

    rcf_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.remote_format     <= 1'b0;
            cfg_reg.channel_mask      <= rcf_pkg::MASK_RESET;
            cfg_reg.keep_channel_bits <= 1'b0;
            cfg_reg.repeat_ticks      <= rcf_pkg::REPEAT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rcf_pkg::REG_REMOTE_FORMAT:     cfg_reg.remote_format     <= cfg_data[0];
                rcf_pkg::REG_CHANNEL_MASK:      cfg_reg.channel_mask      <= cfg_data;
                rcf_pkg::REG_KEEP_CHANNEL_BITS: cfg_reg.keep_channel_bits <= cfg_data[0];
                rcf_pkg::REG_REPEAT_TICKS:      cfg_reg.repeat_ticks      <= cfg_data;
                default:                        cfg_reg                   <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/rcf_filter.sv =====
// Channel extraction, stripping, masking and repeat check, with the last-code store.
`default_nettype none

module rcf_filter
#(
    parameter int CODE_BYTES     = 5,
    parameter int MIN_CODE_BYTES = 3,
    parameter int TICK_BITS      = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  rcf_pkg::item_t        item,
    input  rcf_pkg::cfg_t         cfg,
    output rcf_pkg::result_t      result
);

    localparam int WIDE_BYTES  = (CODE_BYTES > rcf_pkg::IN_CODE_BYTES) ?
                                 CODE_BYTES : rcf_pkg::IN_CODE_BYTES;
    localparam int SHOWN_BYTES = (CODE_BYTES < rcf_pkg::OUT_CODE_BYTES) ?
                                 CODE_BYTES : rcf_pkg::OUT_CODE_BYTES;
    localparam int CMP_BITS    = (TICK_BITS > rcf_pkg::CFG_DATA_BITS) ?
                                 TICK_BITS : rcf_pkg::CFG_DATA_BITS;
    localparam int LB          = rcf_pkg::LENGTH_BITS;
    localparam int BB          = rcf_pkg::BYTE_BITS;

    logic [CODE_BYTES-1:0][BB-1:0] last_code_reg, last_code_next;
    logic [TICK_BITS-1:0]          elapsed_reg, elapsed_next;

    logic [WIDE_BYTES-1:0][BB-1:0] wide_bytes;
    logic [CODE_BYTES-1:0][BB-1:0] code_buf;
    logic [CODE_BYTES-1:0][BB-1:0] stripped;
    logic [CODE_BYTES-1:0][BB-1:0] stored;
    logic [3:0]                    nibble_chan;
    logic [BB-1:0]                 chan;
    logic                          len_ok;
    logic                          masked;
    logic                          same;
    logic                          suppress;
    rcf_pkg::result_t              res;

    always_comb
    begin
        wide_bytes = '0;
        wide_bytes[rcf_pkg::IN_CODE_BYTES-1:0] = item.code_bytes;
        code_buf = wide_bytes[CODE_BYTES-1:0];

        len_ok = (item.byte_count >= LB'(MIN_CODE_BYTES)) &&
                 (item.byte_count <= LB'(CODE_BYTES));

        // channel nibble sits in the top of the last received byte
        nibble_chan = '0;
        for (int i = 0; i < CODE_BYTES; i++)
        begin
            if (item.byte_count == LB'(i + 1))
                nibble_chan = code_buf[i][BB-1:4];
        end
        chan = cfg.remote_format ? code_buf[0] : {4'b0000, nibble_chan};

        stripped = code_buf;
        if (!cfg.keep_channel_bits)
        begin
            if (cfg.remote_format)
                stripped[0] = '0;
            else
            begin
                for (int i = 0; i < CODE_BYTES; i++)
                begin
                    if (item.byte_count == LB'(i + 1))
                        stripped[i] = code_buf[i] & rcf_pkg::NIBBLE_MASK;
                    if (item.byte_count == LB'(i + 3))
                        stripped[i] = code_buf[i] - {nibble_chan, 4'b0000};
                end
            end
        end

        masked = (chan >= rcf_pkg::CHANNEL_LIMIT) || !cfg.channel_mask[chan[3:0]];

        same = 1'b1;
        for (int i = 0; i < CODE_BYTES; i++)
        begin
            if ((LB'(i) < item.byte_count) && (last_code_reg[i] != stripped[i]))
                same = 1'b0;
        end
        suppress = same && (CMP_BITS'(elapsed_reg) < CMP_BITS'(cfg.repeat_ticks));

        // a repeat keeps the stored tail, a new code is stored zero-padded
        stored = last_code_reg;
        if (!same)
        begin
            for (int i = 0; i < CODE_BYTES; i++)
                stored[i] = (LB'(i) < item.byte_count) ? stripped[i] : '0;
        end

        res           = '0;
        res.reason    = rcf_pkg::REASON_OK;
        res.channel   = chan;
        if (!len_ok)
        begin
            res.reason  = rcf_pkg::REASON_BAD_LENGTH;
            res.channel = '0;
        end
        else if (masked)
            res.reason = rcf_pkg::REASON_MASKED;
        else if (suppress)
            res.reason = rcf_pkg::REASON_REPEAT;
        else
        begin
            res.accepted = 1'b1;
            for (int i = 0; i < SHOWN_BYTES; i++)
                res.out_bytes[i] = stored[i];
        end

        last_code_next = last_code_reg;
        elapsed_next   = elapsed_reg;
        if (step)
        begin
            if (item.tick)
            begin
                if (elapsed_reg != '1)
                    elapsed_next = elapsed_reg + 1'b1;
            end
            else if (res.accepted)
            begin
                last_code_next = stored;
                elapsed_next   = '0;
            end
        end
    end

    assign result = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_code_reg <= '0;
            elapsed_reg   <= '1;
        end
        else
        begin
            last_code_reg <= last_code_next;
            elapsed_reg   <= elapsed_next;
        end
    end

    a_accept_clears_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        step && !item.tick && res.accepted |=> elapsed_reg == '0)
        else $error("accepted code did not clear the elapsed counter");

    a_tick_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.tick && (elapsed_reg == '1) |=> elapsed_reg == '1)
        else $error("elapsed counter wrapped past saturation");

endmodule

`default_nettype wire
